### hdl/pbfs_pkg.sv
package pbfs_pkg;

    // field widths of the stream payload
    localparam int IDX_W     = 12;
    localparam int CNT_W     = 6;
    localparam int VAL_W     = 32;
    localparam int MAX_FIELD = 32;
    localparam int S_DATA_W  = 56;
    localparam int M_DATA_W  = 32;

    // store geometry
    localparam int TOTAL_BITS_DEF = 4096;
    localparam int WORD_W         = 32;
    localparam int WIN_W          = 2 * WORD_W;
    localparam int SH_W           = 7;

    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clear_en;
        logic load;
        logic commit;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_ctl_sts;

    // ones in the low cnt bits of a window
    function automatic logic [WIN_W-1:0] low_mask(input logic [CNT_W-1:0] cnt);
        low_mask = (WIN_W'(1) << cnt) - WIN_W'(1);
    endfunction

endpackage

### hdl/pbfs_ram.sv
module pbfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                      i_wdata,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single port, registered read that holds between reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/pbfs_ctrl.sv
module pbfs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  pbfs_pkg::t_ctl_sts i_sts,
    output pbfs_pkg::t_ctl_cmd o_cmd
);

    import pbfs_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_s_tready   = 1'b0;
        o_cmd        = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_en = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = ST_RMW;
                end
            end
            ST_RMW: begin
                o_cmd.commit = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

### hdl/pbfs_dpath.sv
module pbfs_dpath #(
    parameter int TOTAL_BITS = pbfs_pkg::TOTAL_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pbfs_pkg::t_ctl_cmd             i_cmd,
    output pbfs_pkg::t_ctl_sts             o_sts,
    input  logic [pbfs_pkg::S_DATA_W-1:0]  i_s_tdata,
    input  logic                           i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [pbfs_pkg::M_DATA_W-1:0]  o_m_tdata,
    output logic                           o_m_tuser
);

    import pbfs_pkg::*;

    localparam int WORDS = (TOTAL_BITS + WORD_W - 1) / WORD_W;
    localparam int ROWS  = (WORDS + 1) / 2;
    localparam int ROW_W = ROWS > 1 ? $clog2(ROWS) : 1;
    localparam int WI_W  = IDX_W - 4;

    // input fields
    logic [IDX_W-1:0] in_idx;
    logic [CNT_W-1:0] in_cnt;
    logic [VAL_W-1:0] in_val;
    t_cmd             in_cmd;

    // field geometry of the incoming item
    logic [CNT_W-1:0] c_sat;
    logic [WI_W-1:0]  w_a;
    logic [WI_W-1:0]  w_b;
    logic [SH_W-1:0]  sh;
    logic [31:0]      base;
    logic [31:0]      diff;
    logic [SH_W-1:0]  rem;
    logic [WIN_W-1:0] fmask;
    logic [WIN_W-1:0] rmask;
    logic             over;

    // registered item
    t_cmd             r_cmd;
    logic             r_odd;
    logic             r_va;
    logic             r_vb;
    logic [ROW_W-1:0] r_row0;
    logic [ROW_W-1:0] r_row1;
    logic [SH_W-1:0]  r_sh;
    logic [WIN_W-1:0] r_mask;
    logic [WIN_W-1:0] r_wdata;
    logic             r_over;

    // clearing sweep and output register
    logic [ROW_W-1:0]    r_clr_row;
    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;
    logic                r_out_over;

    // banks
    logic [ROW_W-1:0]  ram_addr0;
    logic [ROW_W-1:0]  ram_addr1;
    logic              ram_we0;
    logic              ram_we1;
    logic [WORD_W-1:0] ram_wd0;
    logic [WORD_W-1:0] ram_wd1;
    logic [WORD_W-1:0] ram_q0;
    logic [WORD_W-1:0] ram_q1;
    logic [WIN_W-1:0]  win;
    logic [WIN_W-1:0]  win_new;
    logic [M_DATA_W-1:0] rd_field;

    // unpack the input item
    assign in_idx = i_s_tdata[IDX_W-1:0];
    assign in_cnt = i_s_tdata[IDX_W +: CNT_W];
    assign in_val = i_s_tdata[IDX_W+CNT_W +: VAL_W];
    assign in_cmd = t_cmd'(i_s_tuser);

    // field placement in the two-word window
    always_comb begin
        c_sat = (in_cnt > CNT_W'(MAX_FIELD)) ? CNT_W'(MAX_FIELD) : in_cnt;
        w_a   = {1'b0, in_idx[IDX_W-1:5]};
        w_b   = w_a + WI_W'(1);
        sh    = SH_W'(WIN_W) - SH_W'(in_idx[4:0]) - SH_W'(c_sat);
        base  = 32'({in_idx[IDX_W-1:5], 5'b0});
        diff  = 32'(TOTAL_BITS) - base;
        if (base >= 32'(TOTAL_BITS)) begin
            rem = '0;
        end else if (diff >= 32'(WIN_W)) begin
            rem = SH_W'(WIN_W);
        end else begin
            rem = SH_W'(diff);
        end
        rmask = ~({WIN_W{1'b1}} >> rem);
        fmask = (low_mask(c_sat) << sh) & rmask;
        over  = (c_sat != '0) && ((32'(in_idx) + 32'(c_sat)) > 32'(TOTAL_BITS));
    end

    // capture the item at acceptance
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= in_cmd;
            r_odd   <= w_a[0];
            r_va    <= 32'(w_a) < 32'(WORDS);
            r_vb    <= 32'(w_b) < 32'(WORDS);
            r_row0  <= ROW_W'(w_b[WI_W-1:1]);
            r_row1  <= ROW_W'(w_a[WI_W-1:1]);
            r_sh    <= sh;
            r_mask  <= fmask;
            r_wdata <= (WIN_W'(in_val) & low_mask(c_sat)) << sh;
            r_over  <= over;
        end
    end

    // clearing sweep row counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_row <= '0;
        end else if (i_cmd.clear_en) begin
            r_clr_row <= r_clr_row + ROW_W'(1);
        end
    end

    assign o_sts.clear_last = (r_clr_row == ROW_W'(ROWS - 1));
    assign o_sts.out_free   = !r_out_valid || i_m_tready;

    // window from the two banks, first word on top
    assign win     = r_odd ? {ram_q1, ram_q0} : {ram_q0, ram_q1};
    assign win_new = (win & ~r_mask) | (r_wdata & r_mask);
    assign rd_field = M_DATA_W'((win & r_mask) >> r_sh);

    // bank addresses and writes
    always_comb begin
        if (i_cmd.clear_en) begin
            ram_addr0 = r_clr_row;
            ram_addr1 = r_clr_row;
        end else if (i_cmd.load) begin
            ram_addr0 = ROW_W'(w_b[WI_W-1:1]);
            ram_addr1 = ROW_W'(w_a[WI_W-1:1]);
        end else begin
            ram_addr0 = r_row0;
            ram_addr1 = r_row1;
        end
        if (i_cmd.clear_en) begin
            ram_we0 = 1'b1;
            ram_we1 = 1'b1;
            ram_wd0 = '0;
            ram_wd1 = '0;
        end else begin
            ram_we0 = i_cmd.commit && (r_cmd == CMD_WRITE) && (r_odd ? r_vb : r_va);
            ram_we1 = i_cmd.commit && (r_cmd == CMD_WRITE) && (r_odd ? r_va : r_vb);
            ram_wd0 = r_odd ? win_new[WORD_W-1:0] : win_new[WIN_W-1:WORD_W];
            ram_wd1 = r_odd ? win_new[WIN_W-1:WORD_W] : win_new[WORD_W-1:0];
        end
    end

    pbfs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS)
    ) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (ram_we0),
        .i_re    (i_cmd.load),
        .i_addr  (ram_addr0),
        .i_wdata (ram_wd0),
        .o_rdata (ram_q0)
    );

    pbfs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS)
    ) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (ram_we1),
        .i_re    (i_cmd.load),
        .i_addr  (ram_addr1),
        .i_wdata (ram_wd1),
        .o_rdata (ram_q1)
    );

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= (r_cmd == CMD_WRITE) ? '0 : rd_field;
            r_out_over <= r_over;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_over;

    // a result never overwrites one still waiting
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || i_m_tready))
        else $error("result overwritten before taken");

    // every commit shows a result next cycle
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("commit lost its result");

    // sweep never overlaps item traffic
    a_clear_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_en |-> (!i_cmd.load && !i_cmd.commit))
        else $error("item traffic during clearing sweep");

    // an empty field never reports overrun
    a_zero_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && c_sat == '0) |=> (!r_over && r_mask == '0))
        else $error("empty field flagged or masked");

endmodule

### hdl/packed_bit_field_store.sv
// result: valid once the read-modify-write state has committed it; the read is made at
//   acceptance and the result register is loaded at commit, which waits for a free output
// items: a new item is not accepted until the previous one has been committed, as the
//   32-bit store banks are read at acceptance and written back at commit
// reset: synchronous, active low; a clearing pass over all ceil(ceil(TOTAL_BITS/32)/2)
//   rows (64 at 4096 bits) zeroes the banks, with o_s_tready low throughout
module packed_bit_field_store #(
    parameter int TOTAL_BITS = pbfs_pkg::TOTAL_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [pbfs_pkg::S_DATA_W-1:0] i_s_tdata,  // bit_index, bit_count, write_value, zero pad
    input  logic                          i_s_tuser,  // cmd
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [pbfs_pkg::M_DATA_W-1:0] o_m_tdata,  // read_data
    output logic                          o_m_tuser   // overrun
);

    import pbfs_pkg::*;

    t_ctl_cmd ctl_cmd;
    t_ctl_sts ctl_sts;

    // sequencer
    pbfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (ctl_sts),
        .o_cmd      (ctl_cmd)
    );

    // store banks, field alignment and output register
    pbfs_dpath #(
        .TOTAL_BITS (TOTAL_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (ctl_cmd),
        .o_sts      (ctl_sts),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
